>>> rtl/ldsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsd_pkg
// Shared types and constants for the stopping-distance search block.
// ----------------------------------------------------------------------------
package ldsd_pkg;

    localparam int ROW_W  = 32;
    localparam int COLS_W = 6;
    localparam int DIST_W = 6;

    localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             row_last;
    } row_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] stopping_distance;
        logic              none_found;
        logic              row_overflow;
    } result_t;

    typedef struct packed {
        logic load;
        logic init;
        logic read;
        logic next_row;
        logic step;
        logic next_mask;
        logic next_size;
        logic set_found;
        logic set_none;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic no_search;
        logic row_single;
        logic row_end;
        logic exhausted;
        logic size_final;
    } status_t;

endpackage

>>> rtl/ldsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsd_ctrl
// Sequencer: row loading, subset scan, mask advance and result strobe.
// ----------------------------------------------------------------------------
module ldsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             row_last,
    input  ldsd_pkg::status_t sts,
    output ldsd_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);
    import ldsd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_INIT = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_TEST = 7'b0001000,
        ST_STEP = 7'b0010000,
        ST_DONE = 7'b0100000,
        ST_HOLD = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (row_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (sts.no_search)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (sts.row_single)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_STEP;
                end
                else if (sts.row_end)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.next_row = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_STEP:
            begin
                if (!sts.exhausted)
                begin
                    cmd.next_mask = 1'b1;
                    state_next    = ST_READ;
                end
                else if (sts.size_final)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.next_size = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_DONE:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && row_last) |=> (busy && !done))
        else $error("final row did not start a search");
    a_row_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !row_last) |=> !busy)
        else $error("plain row left the block busy");
`endif

endmodule

>>> rtl/ldsd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsd_datapath
// Row store, column register, subset mask with next-combination step,
// row test and result registers.
// ----------------------------------------------------------------------------
module ldsd_datapath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ldsd_pkg::cmd_t              cmd,
    input  logic [ldsd_pkg::ROW_W-1:0]  row_bits,
    input  logic                        cfg_we,
    input  logic [ldsd_pkg::COLS_W-1:0] cfg_wdata,
    output ldsd_pkg::status_t           sts,
    output ldsd_pkg::result_t           result
);
    import ldsd_pkg::*;

    localparam int MW    = MAX_COLS;
    localparam int MWP   = MAX_COLS + 1;
    localparam int IW    = $clog2(MAX_ROWS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int SW    = $clog2(MAX_ROWS + 2);
    localparam int NW    = $clog2(MW + 2);
    localparam int MAXW  = (SW > NW) ? ((SW > COLS_W) ? SW : COLS_W)
                                     : ((NW > COLS_W) ? NW : COLS_W);
    localparam int CMP_W = MAXW + 1;

    function automatic logic [MWP-1:0] low_ones(input logic [NW-1:0] n);
        logic [MWP-1:0] v;
        v = '0;
        for (int i = 0; i < MWP; i++)
        begin
            v[i] = (NW'(i) < n);
        end
        return v;
    endfunction

    function automatic logic [MW-1:0] low_mask(input logic [NW-1:0] n);
        logic [MWP-1:0] v;
        v = low_ones(n);
        return v[MW-1:0];
    endfunction

    logic [ROW_W-1:0]  mem [MAX_ROWS];
    logic [ROW_W-1:0]  rd_reg;
    logic [RCW-1:0]    rows_reg;
    logic              ovf_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [SW-1:0]     s_reg;
    logic [SW-1:0]     s_next;
    logic [MW-1:0]     mask_reg;
    logic [MW-1:0]     mask_next;
    logic [IW-1:0]     idx_reg;
    logic [MWP-1:0]    r_reg;
    logic [MWP-1:0]    d_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              none_reg;

    logic [NW-1:0]     ncols;
    logic              room;
    logic [MW-1:0]     lowbit;
    logic [MWP-1:0]    r_calc;
    logic [MW-1:0]     hit;
    logic [NW-1:0]     fill_cnt;
    logic [CMP_W-1:0]  s_plus;

    assign ncols = (CMP_W'(cols_reg) > CMP_W'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(cols_reg);
    assign room  = (rows_reg < RCW'(MAX_ROWS));

    assign lowbit   = mask_reg & (~mask_reg + 1'b1);
    assign r_calc   = {1'b0, mask_reg} + {1'b0, lowbit};
    assign hit      = MW'(rd_reg) & mask_reg;
    assign fill_cnt = NW'($countones(d_reg) - 2);
    assign s_plus   = CMP_W'(s_reg) + 1'b1;

    assign sts.no_search  = (rows_reg < RCW'(2)) || (ncols < NW'(2));
    assign sts.row_single = (hit != '0) && ((hit & (hit - 1'b1)) == '0);
    assign sts.row_end    = (idx_reg == IW'(rows_reg - 1'b1));
    assign sts.exhausted  = ((r_reg & ~low_ones(ncols)) != '0);
    assign sts.size_final = (s_plus > CMP_W'(rows_reg)) || (s_plus > CMP_W'(ncols));

    always_comb
    begin
        s_next    = s_reg;
        mask_next = mask_reg;
        if (cmd.init)
        begin
            s_next    = SW'(2);
            mask_next = low_mask(NW'(2));
        end
        else if (cmd.next_mask)
        begin
            mask_next = r_reg[MW-1:0] | low_mask(fill_cnt);
        end
        else if (cmd.next_size)
        begin
            s_next    = SW'(s_plus);
            mask_next = low_mask(NW'(s_plus));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[rows_reg[IW-1:0]] <= row_bits;
        end
        if (cmd.read)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        mask_reg <= mask_next;
        if (cmd.init || cmd.next_mask || cmd.next_size)
        begin
            idx_reg <= '0;
        end
        else if (cmd.next_row)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.step)
        begin
            r_reg <= r_calc;
            d_reg <= r_calc ^ {1'b0, mask_reg};
        end
        if (cmd.set_found)
        begin
            dist_reg <= DIST_W'(s_reg);
            none_reg <= 1'b0;
        end
        else if (cmd.set_none)
        begin
            dist_reg <= DIST_W'(CMP_W'(rows_reg) + 1'b1);
            none_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            ovf_reg  <= 1'b0;
            cols_reg <= COLS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                cols_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                rows_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (room)
                begin
                    rows_reg <= rows_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    assign result.stopping_distance = dist_reg;
    assign result.none_found        = none_reg;
    assign result.row_overflow      = ovf_reg;

`ifndef SYNTHESIS
    a_mask_weight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> ($countones(mask_reg) == int'(s_reg)))
        else $error("subset mask weight differs from subset size");
    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (({1'b0, mask_reg} & ~low_ones(ncols)) == '0))
        else $error("subset mask reaches past the columns in use");
    a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |-> (CMP_W'(s_reg) <= CMP_W'(rows_reg)))
        else $error("reported size exceeds the row count");
`endif

endmodule

>>> rtl/ldpc_stopping_distance_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpc_stopping_distance_search
// Loads parity-check rows and searches column subsets for the smallest
// stopping set once the final row has arrived.
// ----------------------------------------------------------------------------
//  channel   signals                       transfer
//  rows in   start, busy, row_in           start high and busy low
//  config    cfg_we, cfg_wdata             cfg_we high, no wait
//  result    done, result                  done high for one cycle
//
//  A row without row_last is stored while the block stays idle, ready for
//  the next row. The final row starts the search; busy stays high up to and
//  including the result strobe cycle. A set-up state follows the final row.
//  Each candidate subset is tested row by row (single-port row store read,
//  then test), stopping at the first row that breaks it, then stepped to
//  the next subset. The result strobe comes in the cycle after the deciding
//  test, step or set-up. Reset clears the row count and sets the column
//  count to 32. The receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module ldpc_stopping_distance_search #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ldsd_pkg::row_item_t         row_in,
    input  logic                        cfg_we,
    input  logic [ldsd_pkg::COLS_W-1:0] cfg_wdata,
    output logic                        done,
    output ldsd_pkg::result_t           result
);
    import ldsd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    ldsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .row_last (row_in.row_last),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    ldsd_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row_bits  (row_in.row_bits),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sts       (sts),
        .result    (result)
    );

endmodule
